[src/sds_pkg.sv]
// Package for the SCAN disk scheduler: sizes, cell and sequencer types,
// configuration register map. No dependencies.
package sds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_WIDTH    = 16;
	localparam int FIELD_W      = 16;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int MOVE_W       = 18;
	localparam int SUM_W        = ((MOVE_W > CYL_WIDTH) ? MOVE_W : CYL_WIDTH) + 1;
	localparam int ADDR_W       = 4;
	localparam int REG_IDX_W    = 2;
	localparam int DATA_W       = 32;

	localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_CYL_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_POS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_DOWN = 2'd2;

	localparam logic [FIELD_W-1:0] CYL_COUNT_RESET = 16'hFFFF;

	typedef logic [CYL_WIDTH-1:0] cyl_t;

	typedef struct packed {
		logic valid;
		cyl_t cyl;
	} cell_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT_DN,
		CELL_SHIFT_UP
	} cell_op_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic done;
		logic ovf;
		cyl_t cyl;
	} emit_t;

endpackage

[src/scan_disk_scheduler_core.sv]
// SCAN (elevator) disk scheduler: request loading, batch sequencer and
// configuration registers. Depends on sds_pkg, sds_chain, sds_move.
//
// Requests are taken one per cycle while busy is low and kept sorted in an
// insertion chain of 32 cells. A request with last_request set starts the
// schedule and raises busy: the chain first hands every request below the
// head to a second chain used as a stack and drops those on the head, then
// one result leaves per cycle within each phase of the sweep. Each result
// is held until the sequencer picks the entry after it (or closes the batch)
// and leaves once that pick has passed the s1, s2 and output registers of
// sds_move; each is on result_valid for a single cycle and the receiver
// cannot stall. Requests beyond 32 in a batch are dropped and flagged on
// every result of that batch.
module scan_disk_scheduler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sds_pkg::ADDR_W-1:0]    paddr,
	input  logic [sds_pkg::DATA_W-1:0]    pwdata,
	output logic [sds_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [sds_pkg::FIELD_W-1:0]   request_cylinder,
	input  logic                          last_request,
	output logic                          result_valid,
	output logic [sds_pkg::FIELD_W-1:0]   seek_cylinder,
	output logic [sds_pkg::MOVE_W-1:0]    head_movement,
	output logic                          final_entry,
	output logic                          overflow
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_SPLIT,
		S_UP,
		S_POS,
		S_STACK,
		S_ZERO,
		S_CHAIN,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [sds_pkg::CNT_W-1:0]      count_q;
	logic                           dropped_q;
	logic                           pos_pend_q, top_pend_q, first_q;
	logic [sds_pkg::FIELD_W-1:0]    cyl_count_q, start_pos_q;
	logic                           sweep_down_q;

	logic [sds_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           cfg_wr, accept, emitting;
	sds_pkg::cyl_t                  pos, top, cnt;
	sds_pkg::cell_op_t              sort_op, stack_op;
	sds_pkg::cell_t                 sort_head, stack_head;
	sds_pkg::emit_t                 emit;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[sds_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			sds_pkg::REG_CYL_COUNT:  prdata = sds_pkg::DATA_W'(cyl_count_q);
			sds_pkg::REG_START_POS:  prdata = sds_pkg::DATA_W'(start_pos_q);
			sds_pkg::REG_SWEEP_DOWN: prdata = sds_pkg::DATA_W'(sweep_down_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_count_q  <= sds_pkg::CYL_COUNT_RESET;
			start_pos_q  <= '0;
			sweep_down_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				sds_pkg::REG_CYL_COUNT:  cyl_count_q  <= pwdata[sds_pkg::FIELD_W-1:0];
				sds_pkg::REG_START_POS:  start_pos_q  <= pwdata[sds_pkg::FIELD_W-1:0];
				sds_pkg::REG_SWEEP_DOWN: sweep_down_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	assign pos = sds_pkg::CYL_WIDTH'(start_pos_q);
	assign cnt = sds_pkg::CYL_WIDTH'(cyl_count_q);
	assign top = (cnt == '0) ? '0 : cnt - 1'b1;

	assign busy   = (state_q != S_LOAD);
	assign accept = start && !busy;

	sds_chain u_sort (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (sort_op),
		.x     (sds_pkg::CYL_WIDTH'(request_cylinder)),
		.head  (sort_head)
	);

	sds_chain u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (stack_op),
		.x     (sort_head.cyl),
		.head  (stack_head)
	);

	// sequencer datapath
	always_comb begin
		sort_op    = sds_pkg::CELL_HOLD;
		stack_op   = sds_pkg::CELL_HOLD;
		emit.valid = 1'b0;
		emit.first = first_q;
		emit.done  = 1'b0;
		emit.ovf   = dropped_q;
		emit.cyl   = pos;
		case (state_q)
			S_LOAD: begin
				if (accept && (count_q < sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS))) begin
					sort_op = sds_pkg::CELL_INSERT;
				end
			end
			S_SPLIT: begin
				if (sort_head.valid && (sort_head.cyl <= pos)) begin
					sort_op = sds_pkg::CELL_SHIFT_DN;
					if (sort_head.cyl < pos) begin
						stack_op = sds_pkg::CELL_SHIFT_UP;
					end
				end
			end
			S_UP: begin
				if (pos_pend_q) begin
					emit.valid = 1'b1;
					emit.cyl   = (top_pend_q && (top < pos)) ? top : pos;
				end else if (top_pend_q && (!sort_head.valid || (top <= sort_head.cyl))) begin
					emit.valid = 1'b1;
					emit.cyl   = top;
				end else if (sort_head.valid) begin
					emit.valid = 1'b1;
					emit.cyl   = sort_head.cyl;
					sort_op    = sds_pkg::CELL_SHIFT_DN;
				end
			end
			S_POS: begin
				emit.valid = 1'b1;
				emit.cyl   = pos;
			end
			S_STACK: begin
				if (stack_head.valid) begin
					emit.valid = 1'b1;
					emit.cyl   = stack_head.cyl;
					stack_op   = sds_pkg::CELL_SHIFT_DN;
				end
			end
			S_ZERO: begin
				emit.valid = 1'b1;
				emit.cyl   = '0;
			end
			S_CHAIN: begin
				if (sort_head.valid) begin
					emit.valid = 1'b1;
					emit.cyl   = sort_head.cyl;
					sort_op    = sds_pkg::CELL_SHIFT_DN;
				end
			end
			S_DONE: begin
				emit.done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign emitting = emit.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			pos_pend_q <= 1'b0;
			top_pend_q <= 1'b0;
			first_q    <= 1'b0;
		end else begin
			if (emitting) begin
				first_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (count_q < sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS)) begin
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_request) begin
							state_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (!(sort_head.valid && (sort_head.cyl <= pos))) begin
						first_q <= 1'b1;
						if (sweep_down_q) begin
							state_q <= S_POS;
						end else begin
							state_q    <= S_UP;
							pos_pend_q <= 1'b1;
							top_pend_q <= stack_head.valid;
						end
					end
				end
				S_UP: begin
					if (pos_pend_q) begin
						if (top_pend_q && (top < pos)) begin
							top_pend_q <= 1'b0;
						end else begin
							pos_pend_q <= 1'b0;
						end
					end else if (top_pend_q &&
					             (!sort_head.valid || (top <= sort_head.cyl))) begin
						top_pend_q <= 1'b0;
					end else if (!sort_head.valid) begin
						state_q <= S_STACK;
					end
				end
				S_POS: begin
					state_q <= S_STACK;
				end
				S_STACK: begin
					if (!stack_head.valid) begin
						state_q <= sort_head.valid ? S_ZERO : S_DONE;
					end
				end
				S_ZERO: begin
					state_q <= S_CHAIN;
				end
				S_CHAIN: begin
					if (!sort_head.valid) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					state_q   <= S_LOAD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	sds_move u_move (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit         (emit),
		.start_pos    (pos),
		.result_valid (result_valid),
		.seek_cylinder(seek_cylinder),
		.head_movement(head_movement),
		.final_entry  (final_entry),
		.overflow     (overflow)
	);

endmodule

[src/sds_cell.sv]
// One cell of a cylinder chain: holds one value, inserts in order, shifts
// toward either neighbor. Depends on sds_pkg.
module sds_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  sds_pkg::cell_op_t op,
	input  sds_pkg::cyl_t    x,
	input  sds_pkg::cell_t   lo,
	input  logic             lo_gt,
	input  sds_pkg::cell_t   hi,
	output sds_pkg::cell_t   q,
	output logic             gt
);

	logic           valid_q;
	sds_pkg::cyl_t  cyl_q;
	sds_pkg::cell_t nxt;

	assign q.valid = valid_q;
	assign q.cyl   = cyl_q;

	// new value belongs at or below this cell
	assign gt = !valid_q || (x < cyl_q);

	always_comb begin
		nxt = q;
		case (op)
			sds_pkg::CELL_HOLD: begin
				nxt = q;
			end
			sds_pkg::CELL_INSERT: begin
				if (gt) begin
					if (lo_gt) begin
						nxt = lo;
					end else begin
						nxt.valid = 1'b1;
						nxt.cyl   = x;
					end
				end
			end
			sds_pkg::CELL_SHIFT_DN: begin
				nxt = hi;
			end
			sds_pkg::CELL_SHIFT_UP: begin
				nxt = lo;
			end
			default: begin
				nxt = q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		cyl_q <= nxt.cyl;
	end

endmodule

[src/sds_chain.sv]
// Row of sds_cell instances; cell 0 is the access end (smallest value for
// the sorted chain, top of stack for the stack). Depends on sds_pkg, sds_cell.
module sds_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  sds_pkg::cell_op_t op,
	input  sds_pkg::cyl_t     x,
	output sds_pkg::cell_t    head
);

	sds_pkg::cell_t                    cells [sds_pkg::MAX_REQUESTS];
	logic [sds_pkg::MAX_REQUESTS-1:0]  gt;
	sds_pkg::cell_t                    entry;
	sds_pkg::cell_t                    empty;

	assign entry.valid = 1'b1;
	assign entry.cyl   = x;
	assign empty.valid = 1'b0;
	assign empty.cyl   = '0;

	assign head = cells[0];

	for (genvar i = 0; i < sds_pkg::MAX_REQUESTS; i++) begin : g_cell
		sds_pkg::cell_t lo;
		sds_pkg::cell_t hi;
		logic           lo_gt;

		if (i == 0) begin : g_bot
			assign lo    = entry;
			assign lo_gt = 1'b0;
		end else begin : g_mid
			assign lo    = cells[i-1];
			assign lo_gt = gt[i-1];
		end

		if (i == sds_pkg::MAX_REQUESTS - 1) begin : g_top
			assign hi = empty;
		end else begin : g_below
			assign hi = cells[i+1];
		end

		sds_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.op    (op),
			.x     (x),
			.lo    (lo),
			.lo_gt (lo_gt),
			.hi    (hi),
			.q     (cells[i]),
			.gt    (gt[i])
		);
	end

endmodule

[src/sds_move.sv]
// Result pipeline: seek distance, saturating running head movement, and the
// one-deep hold that marks the final entry of a batch. Depends on sds_pkg.
module sds_move (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sds_pkg::emit_t               emit,
	input  sds_pkg::cyl_t                start_pos,
	output logic                         result_valid,
	output logic [sds_pkg::FIELD_W-1:0]  seek_cylinder,
	output logic [sds_pkg::MOVE_W-1:0]   head_movement,
	output logic                         final_entry,
	output logic                         overflow
);

	logic                         valid_s1, first_s1, done_s1, ovf_s1;
	sds_pkg::cyl_t                cyl_s1;
	logic                         valid_s2, first_s2, done_s2, ovf_s2;
	sds_pkg::cyl_t                cyl_s2, diff_s2;
	sds_pkg::cyl_t                prev_q;
	logic                         hold_valid_q, hold_ovf_q;
	sds_pkg::cyl_t                hold_cyl_q;
	logic [sds_pkg::MOVE_W-1:0]   mov_q;
	logic                         out_valid_q, out_final_q, out_ovf_q;
	logic [sds_pkg::FIELD_W-1:0]  out_cyl_q;
	logic [sds_pkg::MOVE_W-1:0]   out_mov_q;

	sds_pkg::cyl_t                base_head, diff;
	logic [sds_pkg::MOVE_W-1:0]   base_mov, mov_next;
	logic [sds_pkg::SUM_W-1:0]    sum;

	assign base_head = first_s1 ? start_pos : prev_q;
	assign diff      = (cyl_s1 >= base_head) ? (cyl_s1 - base_head) : (base_head - cyl_s1);

	assign base_mov  = first_s2 ? '0 : mov_q;
	assign sum       = sds_pkg::SUM_W'(base_mov) + sds_pkg::SUM_W'(diff_s2);
	assign mov_next  = (sum > sds_pkg::SUM_W'(sds_pkg::MOVE_MAX)) ? sds_pkg::MOVE_MAX
	                 : sds_pkg::MOVE_W'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			done_s1      <= 1'b0;
			valid_s2     <= 1'b0;
			done_s2      <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			valid_s1 <= emit.valid;
			done_s1  <= emit.done;
			valid_s2 <= valid_s1;
			done_s2  <= done_s1;
			if (valid_s2) begin
				hold_valid_q <= 1'b1;
			end else if (done_s2) begin
				hold_valid_q <= 1'b0;
			end
			out_valid_q <= hold_valid_q && (valid_s2 || done_s2);
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= emit.first;
		ovf_s1   <= emit.ovf;
		cyl_s1   <= emit.cyl;
		if (valid_s1) begin
			prev_q <= cyl_s1;
		end
		first_s2 <= first_s1;
		ovf_s2   <= ovf_s1;
		cyl_s2   <= cyl_s1;
		diff_s2  <= diff;
		if (valid_s2) begin
			hold_cyl_q <= cyl_s2;
			hold_ovf_q <= ovf_s2;
			mov_q      <= mov_next;
		end
		out_final_q <= done_s2;
		out_cyl_q   <= sds_pkg::FIELD_W'(hold_cyl_q);
		out_mov_q   <= mov_q;
		out_ovf_q   <= hold_ovf_q;
	end

	assign result_valid  = out_valid_q;
	assign seek_cylinder = out_cyl_q;
	assign head_movement = out_mov_q;
	assign final_entry   = out_final_q;
	assign overflow      = out_ovf_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for scan_disk_scheduler_core: a directed table, then random request batches.
// Results are checked against the SCAN order the bench computes or a typed row's entry.
// Depends on sds_pkg and the scheduler RTL.
module tb;
	import sds_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 300;
	localparam int PLAN_ROWS    = 27;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		cyl_t              seek;
		logic [MOVE_W-1:0] moved;
		logic              fin;
		logic              ovf;
	} visit_t;

	// geometry row: a = cylinder count, b = head, flag = sweep down
	// request row:  a = cylinder, flag = last request
	typedef struct {
		logic   geometry;
		cyl_t   a;
		cyl_t   b;
		logic   flag;
		logic   typed;
		visit_t want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic [FIELD_W-1:0]  request_cylinder = '0;
	logic                last_request = 1'b0;
	logic                result_valid;
	logic [FIELD_W-1:0]  seek_cylinder;
	logic [MOVE_W-1:0]   head_movement;
	logic                final_entry;
	logic                overflow;

	cyl_t                held[MAX_REQUESTS];
	int                  held_n = 0;
	logic                dropped = 1'b0;
	logic [FIELD_W-1:0]  cyl_count_r = CYL_COUNT_RESET;
	logic [FIELD_W-1:0]  head_r = '0;
	logic                sweep_r = 1'b0;

	visit_t              visits_due[$];
	int                  mismatches = 0;
	int                  stalled = 0;
	int                  idle_pct = 0;
	logic                holding = 1'b0;
	row_t                plan[PLAN_ROWS];

	scan_disk_scheduler_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.start            (start),
		.busy             (busy),
		.request_cylinder (request_cylinder),
		.last_request     (last_request),
		.result_valid     (result_valid),
		.seek_cylinder    (seek_cylinder),
		.head_movement    (head_movement),
		.final_entry      (final_entry),
		.overflow         (overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic row_t geom(input int count, input int head, input logic down);
		row_t r;
		r = '{1'b1, cyl_t'(count), cyl_t'(head), down, 1'b0, '{'0, '0, 1'b0, 1'b0}};
		return r;
	endfunction

	function automatic row_t req(input int c, input logic last);
		row_t r;
		r = '{1'b0, cyl_t'(c), '0, last, 1'b0, '{'0, '0, 1'b0, 1'b0}};
		return r;
	endfunction

	// batch of one request sitting on the head: only the head entry comes out
	function automatic row_t lone(input int c);
		row_t r;
		r = '{1'b0, cyl_t'(c), '0, 1'b1, 1'b1, '{cyl_t'(c), '0, 1'b1, 1'b0}};
		return r;
	endfunction

	task automatic order_up(ref int v[$]);
		int i, j, x;
		for (i = 1; i < v.size(); i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
	endtask

	task automatic visit(input int c, inout int cur, inout int moved, ref visit_t out[$]);
		visit_t v;
		moved += (c > cur) ? c - cur : cur - c;
		if (moved > int'(MOVE_MAX))
			moved = int'(MOVE_MAX);
		cur = c;
		v.seek = cyl_t'(c);
		v.moved = moved[MOVE_W-1:0];
		v.fin = 1'b0;
		v.ovf = dropped;
		out.push_back(v);
	endtask

	// store one request; on the last one build the elevator order
	task automatic take_request(input cyl_t rq, input logic last, ref visit_t out[$]);
		int ahead[$];
		int behind[$];
		int pos, top, cur, moved, r, i;
		logic below, above;
		out.delete();
		if (held_n < MAX_REQUESTS) begin
			held[held_n] = rq;
			held_n++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		pos = int'(head_r);
		top = (cyl_count_r == 0) ? 0 : int'(cyl_count_r) - 1;
		below = 1'b0;
		above = 1'b0;
		ahead.push_back(pos);
		for (i = 0; i < held_n; i++) begin
			r = int'(held[i]);
			if (r < pos)
				below = 1'b1;
			if (r > pos)
				above = 1'b1;
			if (r != pos) begin
				if ((r > pos) ^ sweep_r)
					ahead.push_back(r);
				else
					behind.push_back(r);
			end
		end
		if (!sweep_r && below)
			ahead.push_back(top);
		if (sweep_r && above)
			ahead.push_back(0);
		order_up(ahead);
		order_up(behind);
		cur = pos;
		moved = 0;
		for (i = 0; i < ahead.size(); i++)
			visit(sweep_r ? ahead[ahead.size()-1-i] : ahead[i], cur, moved, out);
		for (i = 0; i < behind.size(); i++)
			visit(sweep_r ? behind[i] : behind[behind.size()-1-i], cur, moved, out);
		out[out.size()-1].fin = 1'b1;
		held_n = 0;
		dropped = 1'b0;
	endtask

	task automatic send_request(input cyl_t rq, input logic last, input logic typed,
			input visit_t want);
		visit_t got[$];
		start <= 1'b1;
		request_cylinder <= rq;
		last_request <= last;
		holding = 1'b1;
		do @(posedge clk); while (busy);
		take_request(rq, last, got);
		if (typed)
			visits_due.push_back(want);
		else
			foreach (got[k]) visits_due.push_back(got[k]);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			holding = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drop start and let the block run dry
	task automatic settle();
		if (holding) begin
			start <= 1'b0;
			holding = 1'b0;
		end
		do @(posedge clk); while (visits_due.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [FIELD_W-1:0] count,
			input logic [FIELD_W-1:0] head, input logic down);
		logic [DATA_W-1:0] junk, rd;
		junk = $urandom;
		apb_transfer(1'b1, REG_CYL_COUNT, {junk[DATA_W-1:FIELD_W], count}, rd);
		junk = $urandom;
		apb_transfer(1'b1, REG_START_POS, {junk[DATA_W-1:FIELD_W], head}, rd);
		junk = $urandom;
		apb_transfer(1'b1, REG_SWEEP_DOWN, {junk[DATA_W-1:1], down}, rd);
		apb_transfer(1'b1, REG_UNUSED, $urandom, rd);
		cyl_count_r = count;
		head_r = head;
		sweep_r = down;
		apb_transfer(1'b0, REG_CYL_COUNT, '0, rd);
		if (rd !== {{(DATA_W-FIELD_W){1'b0}}, count})
			flag_mismatch("cylinder_count readback", rd, count);
		apb_transfer(1'b0, REG_START_POS, '0, rd);
		if (rd !== {{(DATA_W-FIELD_W){1'b0}}, head})
			flag_mismatch("start_position readback", rd, head);
		apb_transfer(1'b0, REG_SWEEP_DOWN, '0, rd);
		if (rd !== {{(DATA_W-1){1'b0}}, down})
			flag_mismatch("sweep_down readback", rd, down);
	endtask

	function automatic logic [FIELD_W-1:0] pick_cylinder();
		int sel, top;
		logic [FIELD_W-1:0] c;
		sel = $urandom_range(99);
		top = (cyl_count_r == 0) ? 0 : int'(cyl_count_r) - 1;
		if (sel < 25)
			c = FIELD_W'($urandom);
		else if (sel < 45)
			c = FIELD_W'(int'(head_r) + $urandom_range(16) - 8);
		else if (sel < 55)
			c = head_r;
		else if (sel < 60)
			c = '0;
		else if (sel < 65)
			c = '1;
		else if (sel < 70)
			c = FIELD_W'(top);
		else
			c = FIELD_W'($urandom_range(top, 0));
		return c;
	endfunction

	function automatic int pick_length();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom_range(1, 6);
		else if (sel < 85)
			return $urandom_range(7, 31);
		else if (sel < 92)
			return MAX_REQUESTS;
		return $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
	endfunction

	always @(posedge clk) begin
		visit_t w;
		if (arst_n && result_valid) begin
			if (visits_due.size() == 0) begin
				flag_mismatch("result with nothing outstanding", seek_cylinder, 0);
			end else begin
				w = visits_due.pop_front();
				if (seek_cylinder !== w.seek)
					flag_mismatch("seek_cylinder", seek_cylinder, w.seek);
				if (head_movement !== w.moved)
					flag_mismatch("head_movement", head_movement, w.moved);
				if (final_entry !== w.fin)
					flag_mismatch("final_entry", final_entry, w.fin);
				if (overflow !== w.ovf)
					flag_mismatch("overflow", overflow, w.ovf);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy) || (psel && penable)) begin
			stalled <= 0;
		end else if (stalled >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	initial begin
		visit_t nil;
		logic [FIELD_W-1:0] count, head;
		int len, b, n_rand, phase, sel;
		nil = '{'0, '0, 1'b0, 1'b0};
		plan = '{
			lone(0), req(65535, 1),
			req(7, 0), req(3, 0), req(65535, 0), req(3, 1),
			geom(200, 100, 0), lone(100),
			req(150, 0), req(50, 0), req(250, 0), req(50, 0), req(199, 1),
			geom(200, 100, 1), req(30, 0), req(170, 0), req(0, 1),
			geom(0, 65535, 1), lone(65535), req(1, 0), req(0, 1),
			geom(1, 32768, 0), req(65535, 0), req(0, 1),
			geom(65535, 65534, 0), req(65535, 0), req(0, 1)
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].geometry) begin
				settle();
				set_geometry(plan[k].a, plan[k].b, plan[k].flag);
			end else begin
				send_request(plan[k].a, plan[k].flag, plan[k].typed, plan[k].want);
			end
		end

		n_rand = 0;
		phase = 0;
		while (n_rand < RANDOM_ITEMS) begin
			settle();
			sel = $urandom_range(99);
			if (sel < 10)
				count = '0;
			else if (sel < 20)
				count = FIELD_W'(1);
			else if (sel < 30)
				count = '1;
			else if (sel < 45)
				count = FIELD_W'($urandom_range(2, 64));
			else
				count = FIELD_W'($urandom);
			sel = $urandom_range(99);
			if (sel < 10)
				head = '0;
			else if (sel < 20)
				head = 16'hFFFE;
			else if (sel < 25)
				head = '1;
			else if (sel < 60)
				head = FIELD_W'($urandom_range(int'(count), 0));
			else
				head = FIELD_W'($urandom);
			set_geometry(count, head, 1'($urandom_range(1)));
			idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 66 : 21;
			repeat ($urandom_range(2, 5)) begin
				len = (n_rand == 0) ? MAX_REQUESTS + 2 : pick_length();
				for (b = 0; b < len; b++)
					send_request(pick_cylinder(), b == len - 1, 1'b0, nil);
				n_rand += len;
			end
			phase++;
		end

		settle();
		repeat (32) @(posedge clk);
		if (mismatches == 0 && visits_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
src/sds_pkg.sv
src/sds_cell.sv
src/sds_chain.sv
src/sds_move.sv
src/scan_disk_scheduler_core.sv
bench/tb.sv
